/* rtl/vxs_pkg.sv */
`default_nettype none

package vxs_pkg;

    localparam int SIDE_DEF       = 16;
    localparam int MAX_LAYERS_DEF = 256;

    localparam int ID_W     = 8;
    localparam int TOP_W    = 9;
    localparam int HEIGHT_W = 9;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd256;
    localparam logic [TOP_W-1:0]    TOP_EMPTY    = 9'h1FF;

    localparam int RAM_DEPTH_DEF = 256;
    localparam int RAM_WIDTH_DEF = 16;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

endpackage

`default_nettype wire

/* rtl/vxs_ram.sv */
`default_nettype none

module vxs_ram #(
    parameter int DEPTH = vxs_pkg::RAM_DEPTH_DEF,
    parameter int WIDTH = vxs_pkg::RAM_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first single port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/voxel_store_with_column_top.sv */
`default_nettype none

// Voxel store with per-column top height. After reset the block runs a clearing pass over
// all SIDE*SIDE*MAX_LAYERS cells (65536 at the defaults), zeroing every cell and setting every
// column top to -1; busy stays high until it ends, while the height register can still be
// written. A request is taken when start is high and busy is low. An ordinary read or write
// first reads the cell and column-top memories, then updates them; o_done pulses for one
// cycle in the cycle after the update, and busy is already low in that cycle, so the next
// request may be issued at once. Writing id 0 into the current top cell of a column starts
// a downward rescan through the cell memory, one layer read per cycle from
// min(column_height, MAX_LAYERS)-1, paced by the single read port of the cell memory.
// Results cannot be held off: capture them in the o_done cycle.
module voxel_store_with_column_top #(
    parameter int SIDE       = vxs_pkg::SIDE_DEF,
    parameter int MAX_LAYERS = vxs_pkg::MAX_LAYERS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           i_op,
    input  wire logic [3:0]                     i_cell_x,
    input  wire logic [7:0]                     i_cell_y,
    input  wire logic [3:0]                     i_cell_z,
    input  wire logic [vxs_pkg::ID_W-1:0]       i_new_id,
    input  wire logic [7:0]                     i_new_state,
    output logic                                o_done,
    output logic      [vxs_pkg::ID_W-1:0]       o_block_id,
    output logic      [7:0]                     o_block_state,
    output logic signed [vxs_pkg::TOP_W-1:0]    o_column_top,
    output logic                                o_in_range,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [vxs_pkg::HEIGHT_W-1:0]   i_cfg_data
);

    import vxs_pkg::*;

    localparam int NCOLS = SIDE * SIDE;
    localparam int CELLS = NCOLS * MAX_LAYERS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(NCOLS);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [3:0] x, input logic [8:0] y,
                                                input logic [3:0] z);
        int a;
        a = int'(x) + SIDE * (int'(z) + SIDE * int'(y));
        return AW'(a);
    endfunction

    function automatic logic [CW-1:0] col_addr(input logic [3:0] x, input logic [3:0] z);
        int a;
        a = int'(x) + SIDE * int'(z);
        return CW'(a);
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [HEIGHT_W-1:0] r_column_height;
    logic r_cfg_ready;

    logic r_op, n_op;
    logic [3:0] r_x, n_x, r_z, n_z;
    logic [7:0] r_y, n_y;
    logic [ID_W-1:0] r_id, n_id;
    logic [7:0] r_st, n_st;
    logic r_col_ok, n_col_ok, r_y_ok, n_y_ok;

    logic [8:0] r_sy, n_sy, r_py, n_py;
    logic r_more, n_more, r_pend, n_pend;

    logic r_done, n_done;
    logic [ID_W-1:0] r_block_id, n_block_id;
    logic [7:0] r_block_state, n_block_state;
    logic [TOP_W-1:0] r_column_top, n_column_top;
    logic r_in_range, n_in_range;

    logic [HEIGHT_W-1:0] eff_height;
    logic in_col_ok, in_y_ok;
    logic scan_hit, raise_top;

    logic cell_we;
    logic [AW-1:0] cell_a;
    logic [15:0] cell_wd, cell_rd;
    logic top_we;
    logic [CW-1:0] top_a;
    logic [TOP_W-1:0] top_wd, top_rd;

    vxs_ram #(.DEPTH(CELLS), .WIDTH(16)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_addr  (cell_a),
        .i_wdata (cell_wd),
        .o_rdata (cell_rd)
    );

    vxs_ram #(.DEPTH(NCOLS), .WIDTH(TOP_W)) u_top_ram (
        .i_clk   (i_clk),
        .i_we    (top_we),
        .i_addr  (top_a),
        .i_wdata (top_wd),
        .o_rdata (top_rd)
    );

    // height above the store's layer count acts as the layer count
    assign eff_height = (int'(r_column_height) > MAX_LAYERS) ? HEIGHT_W'(MAX_LAYERS)
                                                             : r_column_height;
    assign in_col_ok  = (int'(i_cell_x) < SIDE) && (int'(i_cell_z) < SIDE);
    assign in_y_ok    = ({1'b0, i_cell_y} < eff_height);
    assign scan_hit   = r_pend && (cell_rd[ID_W-1:0] != '0);
    assign raise_top  = $signed({1'b0, r_y}) > $signed(top_rd);

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_op          = r_op;
        n_x           = r_x;
        n_y           = r_y;
        n_z           = r_z;
        n_id          = r_id;
        n_st          = r_st;
        n_col_ok      = r_col_ok;
        n_y_ok        = r_y_ok;
        n_sy          = r_sy;
        n_py          = r_py;
        n_more        = r_more;
        n_pend        = r_pend;
        n_done        = 1'b0;
        n_block_id    = r_block_id;
        n_block_state = r_block_state;
        n_column_top  = r_column_top;
        n_in_range    = r_in_range;

        cell_we = 1'b0;
        cell_a  = cell_addr(r_x, {1'b0, r_y}, r_z);
        cell_wd = {r_st, r_id};
        top_we  = 1'b0;
        top_a   = r_col_ok ? col_addr(r_x, r_z) : '0;
        top_wd  = {1'b0, r_y};

        case (r_state)
            S_CLEAR: begin
                cell_we = 1'b1;
                cell_a  = r_clr;
                cell_wd = '0;
                top_we  = (int'(r_clr) < NCOLS);
                top_a   = r_clr[CW-1:0];
                top_wd  = TOP_EMPTY;
                n_clr   = r_clr + 1'b1;
                if (r_clr == AW'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cell_a = (in_col_ok && in_y_ok) ? cell_addr(i_cell_x, {1'b0, i_cell_y}, i_cell_z)
                                                : '0;
                top_a  = in_col_ok ? col_addr(i_cell_x, i_cell_z) : '0;
                if (start) begin
                    n_state  = S_UPDATE;
                    n_op     = i_op;
                    n_x      = i_cell_x;
                    n_y      = i_cell_y;
                    n_z      = i_cell_z;
                    n_id     = i_new_id;
                    n_st     = i_new_state;
                    n_col_ok = in_col_ok;
                    n_y_ok   = in_y_ok;
                end
            end
            S_UPDATE: begin
                n_done        = 1'b1;
                n_state       = S_IDLE;
                n_block_id    = '0;
                n_block_state = '0;
                n_in_range    = 1'b0;
                n_column_top  = r_col_ok ? top_rd : TOP_EMPTY;
                if (r_col_ok && r_y_ok) begin
                    n_in_range = 1'b1;
                    if (t_op'(r_op) == OP_WRITE) begin
                        cell_we       = 1'b1;
                        n_block_id    = r_id;
                        n_block_state = r_st;
                        if (r_id != '0 && raise_top) begin
                            top_we       = 1'b1;
                            n_column_top = {1'b0, r_y};
                        end else if (r_id == '0 && {1'b0, r_y} == top_rd) begin
                            // top cell cleared: rescan the column downward
                            n_done  = 1'b0;
                            n_state = S_SCAN;
                            n_sy    = eff_height - 1'b1;
                            n_more  = 1'b1;
                            n_pend  = 1'b0;
                        end
                    end else begin
                        n_block_id    = cell_rd[ID_W-1:0];
                        n_block_state = cell_rd[15:8];
                    end
                end
            end
            S_SCAN: begin
                cell_a = cell_addr(r_x, r_sy, r_z);
                if (scan_hit || !r_more) begin
                    top_we       = 1'b1;
                    top_wd       = scan_hit ? r_py : TOP_EMPTY;
                    n_column_top = top_wd;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_pend = 1'b1;
                    n_py   = r_sy;
                    if (r_sy == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_sy = r_sy - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_column_height <= HEIGHT_RESET;
            r_cfg_ready     <= 1'b0;
            r_more          <= 1'b0;
            r_pend          <= 1'b0;
            r_done          <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_cfg_ready <= 1'b1;
            r_more      <= n_more;
            r_pend      <= n_pend;
            r_done      <= n_done;
            if (i_cfg_valid && r_cfg_ready) begin
                r_column_height <= i_cfg_data;
            end
        end
        r_op          <= n_op;
        r_x           <= n_x;
        r_y           <= n_y;
        r_z           <= n_z;
        r_id          <= n_id;
        r_st          <= n_st;
        r_col_ok      <= n_col_ok;
        r_y_ok        <= n_y_ok;
        r_sy          <= n_sy;
        r_py          <= n_py;
        r_block_id    <= n_block_id;
        r_block_state <= n_block_state;
        r_column_top  <= n_column_top;
        r_in_range    <= n_in_range;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = r_cfg_ready;
    assign o_done        = r_done;
    assign o_block_id    = r_block_id;
    assign o_block_state = r_block_state;
    assign o_column_top  = $signed(r_column_top);
    assign o_in_range    = r_in_range;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy && $past(busy))
        else $error("result strobe outside the end of a request");

    a_top_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        top_we |-> r_state != S_IDLE)
        else $error("column top written while idle");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_in_range |-> o_block_id == '0 && o_block_state == '0)
        else $error("out of range result carries cell data");
`endif

endmodule

`default_nettype wire

/* tb/sv/voxel_store_with_column_top_test.sv */
`default_nettype none

module voxel_store_with_column_top_test;

    import vxs_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int NUM_CELLS    = SIDE_DEF * SIDE_DEF * MAX_LAYERS_DEF;
    localparam int NUM_COLUMNS  = SIDE_DEF * SIDE_DEF;
    // clearing pass plus the longest rescan, several times over
    localparam int QUIET_LIMIT  = 4 * NUM_CELLS + 8 * (MAX_LAYERS_DEF + 3);
    localparam int TAIL_CYCLES  = 2 * (MAX_LAYERS_DEF + 3);
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [7:0]              state;
        logic signed [TOP_W-1:0] top;
        logic                    in_range;
    } t_access_result;

    typedef struct {
        bit                  is_cfg;
        logic [HEIGHT_W-1:0] height;
        logic                op;
        logic [3:0]          x;
        logic [7:0]          y;
        logic [3:0]          z;
        logic [ID_W-1:0]     id;
        logic [7:0]          st;
        bit                  typed;
        t_access_result      want;
    } t_script_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  i_op = OP_READ;
    logic [3:0]            i_cell_x = '0;
    logic [7:0]            i_cell_y = '0;
    logic [3:0]            i_cell_z = '0;
    logic [ID_W-1:0]       i_new_id = '0;
    logic [7:0]            i_new_state = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [HEIGHT_W-1:0]   i_cfg_data = '0;
    logic                  busy;
    logic                  o_done;
    logic [ID_W-1:0]       o_block_id;
    logic [7:0]            o_block_state;
    logic signed [TOP_W-1:0] o_column_top;
    logic                  o_in_range;
    logic                  o_cfg_ready;

    // mirror of the block's state
    logic [15:0]             cell_mem [NUM_CELLS];
    logic signed [TOP_W-1:0] column_top_mem [NUM_COLUMNS];
    logic [HEIGHT_W-1:0]     height_reg;

    t_access_result pending_results [$];
    bit             typed_request = 1'b0;
    t_access_result typed_result = '0;
    int             fault_count = 0;
    int             quiet_cycles = 0;

    voxel_store_with_column_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_op          (i_op),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_cell_z      (i_cell_z),
        .i_new_id      (i_new_id),
        .i_new_state   (i_new_state),
        .o_done        (o_done),
        .o_block_id    (o_block_id),
        .o_block_state (o_block_state),
        .o_column_top  (o_column_top),
        .o_in_range    (o_in_range),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int live_layers();
        return (int'(height_reg) > MAX_LAYERS_DEF) ? MAX_LAYERS_DEF : int'(height_reg);
    endfunction

    function automatic t_access_result predict_access(logic op, logic [3:0] x, logic [7:0] y,
                                                      logic [3:0] z, logic [ID_W-1:0] id,
                                                      logic [7:0] st);
        t_access_result          r;
        int                      layers;
        logic [7:0]              col;
        logic [15:0]             idx;
        logic signed [TOP_W-1:0] new_top;
        r = '0;
        layers = live_layers();
        col = {z, x};
        idx = {y, z, x};
        if (int'(y) < layers) begin
            r.in_range = 1'b1;
            if (op == OP_WRITE) begin
                cell_mem[idx] = {st, id};
                if (id != '0) begin
                    if (int'(y) > int'(column_top_mem[col]))
                        column_top_mem[col] = {1'b0, y};
                end else if (int'(y) == int'(column_top_mem[col])) begin
                    // rescan: keep the highest non-empty layer below the height
                    new_top = TOP_EMPTY;
                    for (int l = 0; l < layers; l++) begin
                        if (cell_mem[{8'(l), z, x}][7:0] != 8'd0)
                            new_top = TOP_W'(l);
                    end
                    column_top_mem[col] = new_top;
                end
            end
            r.id = cell_mem[idx][7:0];
            r.state = cell_mem[idx][15:8];
        end
        r.top = column_top_mem[col];
        return r;
    endfunction

    task automatic note_fault(input string msg);
        if (fault_count < MAX_REPORTS)
            $display("%s", msg);
        fault_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_access_result want;
        bit             progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                progress = 1'b1;
                if (pending_results.size() == 0) begin
                    note_fault($sformatf("unexpected result: id=%0d state=%0d top=%0d in_range=%0b",
                                         o_block_id, o_block_state, o_column_top, o_in_range));
                end else begin
                    want = pending_results.pop_front();
                    if (o_block_id !== want.id)
                        note_fault($sformatf("block_id: expected %0d, got %0d",
                                             want.id, o_block_id));
                    if (o_block_state !== want.state)
                        note_fault($sformatf("block_state: expected %0d, got %0d",
                                             want.state, o_block_state));
                    if (o_column_top !== want.top)
                        note_fault($sformatf("column_top: expected %0d, got %0d",
                                             want.top, o_column_top));
                    if (o_in_range !== want.in_range)
                        note_fault($sformatf("in_range: expected %0b, got %0b",
                                             want.in_range, o_in_range));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                height_reg = i_cfg_data;
                progress = 1'b1;
            end
            if (start && !busy) begin
                want = predict_access(i_op, i_cell_x, i_cell_y, i_cell_z, i_new_id,
                                      i_new_state);
                pending_results.push_back(typed_request ? typed_result : want);
                progress = 1'b1;
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // hold off new requests until every result is in
    task automatic drain();
        idle_cycle();
        while (pending_results.size() != 0)
            idle_cycle();
    endtask

    task automatic write_height(input logic [HEIGHT_W-1:0] value);
        @(negedge i_clk);
        start <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_access(input logic op, input logic [3:0] x, input logic [7:0] y,
                               input logic [3:0] z, input logic [ID_W-1:0] id,
                               input logic [7:0] st, input bit typed,
                               input t_access_result want);
        @(negedge i_clk);
        start <= 1'b1;
        i_op <= op;
        i_cell_x <= x;
        i_cell_y <= y;
        i_cell_z <= z;
        i_new_id <= id;
        i_new_state <= st;
        typed_request = typed;
        typed_result = want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic run_phase(input int idle_pct, input int count);
        int              pick;
        int              layers;
        logic            op;
        logic [3:0]      x;
        logic [3:0]      z;
        logic [7:0]      y;
        logic [ID_W-1:0] id;
        logic [7:0]      st;
        for (int n = 0; n < count; n++) begin
            while ($urandom_range(0, 99) < idle_pct)
                idle_cycle();
            if ($urandom_range(0, 59) == 0)
                drain();
            layers = live_layers();
            pick = $urandom_range(0, 99);
            op = OP_WRITE;
            x = 4'($urandom_range(0, 3));
            z = 4'($urandom_range(0, 3));
            y = (layers > 0) ? 8'($urandom_range(0, layers - 1)) : 8'($urandom);
            id = ($urandom_range(0, 9) < 3) ? '0 : ID_W'($urandom);
            st = 8'($urandom);
            if (pick < 15) begin
                // clear the current top of a busy column to force a rescan
                id = '0;
                if (int'(column_top_mem[{z, x}]) >= 0 &&
                    int'(column_top_mem[{z, x}]) < layers)
                    y = column_top_mem[{z, x}][7:0];
            end else if (pick < 60) begin
                op = OP_WRITE;
            end else if (pick < 75) begin
                op = OP_READ;
            end else begin
                op = 1'($urandom);
                x = 4'($urandom);
                y = 8'($urandom);
                z = 4'($urandom);
                id = ID_W'($urandom);
            end
            send_access(op, x, y, z, id, st, 1'b0, '0);
        end
    endtask

    function automatic t_script_row access_row(t_op op, logic [3:0] x, logic [7:0] y,
                                               logic [3:0] z, logic [ID_W-1:0] id,
                                               logic [7:0] st);
        t_script_row r;
        r = '{default: '0};
        r.op = op;
        r.x = x;
        r.y = y;
        r.z = z;
        r.id = id;
        r.st = st;
        return r;
    endfunction

    function automatic t_script_row checked_row(t_op op, logic [3:0] x, logic [7:0] y,
                                                logic [3:0] z, logic [ID_W-1:0] id,
                                                logic [7:0] st, logic [ID_W-1:0] want_id,
                                                logic [7:0] want_st,
                                                logic signed [TOP_W-1:0] want_top,
                                                logic want_ok);
        t_script_row r;
        r = access_row(op, x, y, z, id, st);
        r.typed = 1'b1;
        r.want = '{id: want_id, state: want_st, top: want_top, in_range: want_ok};
        return r;
    endfunction

    function automatic t_script_row height_row(logic [HEIGHT_W-1:0] value);
        t_script_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.height = value;
        return r;
    endfunction

    initial begin : stimulus
        t_script_row script [$];
        for (int i = 0; i < NUM_CELLS; i++)
            cell_mem[i] = '0;
        for (int i = 0; i < NUM_COLUMNS; i++)
            column_top_mem[i] = TOP_EMPTY;
        height_reg = HEIGHT_RESET;

        // defaults after reset
        script.push_back(checked_row(OP_READ, 0, 0, 0, 0, 0, 0, 0, TOP_EMPTY, 1));
        script.push_back(checked_row(OP_READ, 15, 255, 15, 0, 0, 0, 0, TOP_EMPTY, 1));
        // raise, keep, and clear the top of one column
        script.push_back(checked_row(OP_WRITE, 3, 10, 5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 10, 1));
        script.push_back(checked_row(OP_WRITE, 3, 200, 5, 8'h01, 8'h00, 8'h01, 0, 200, 1));
        script.push_back(access_row(OP_WRITE, 3, 10, 5, 8'h00, 8'h5A));
        script.push_back(checked_row(OP_WRITE, 3, 200, 5, 0, 0, 0, 0, TOP_EMPTY, 1));
        script.push_back(checked_row(OP_WRITE, 3, 255, 5, 8'h80, 8'h01, 8'h80, 8'h01, 255, 1));
        script.push_back(access_row(OP_WRITE, 3, 0, 5, 8'h07, 8'h09));
        script.push_back(checked_row(OP_WRITE, 3, 255, 5, 0, 0, 0, 0, 0, 1));
        script.push_back(checked_row(OP_WRITE, 15, 255, 15, 8'hAA, 8'h55, 8'hAA, 8'h55, 255, 1));
        script.push_back(access_row(OP_READ, 15, 255, 15, 0, 0));
        // lowered height: upper layers unreachable, top still reported
        script.push_back(height_row(9'd100));
        script.push_back(checked_row(OP_READ, 15, 255, 15, 0, 0, 0, 0, 255, 0));
        script.push_back(access_row(OP_WRITE, 15, 99, 15, 8'h11, 8'h22));
        script.push_back(access_row(OP_WRITE, 15, 50, 15, 8'h00, 8'h33));
        // zero height
        script.push_back(height_row(9'd0));
        script.push_back(checked_row(OP_WRITE, 1, 0, 1, 8'h05, 8'h05, 0, 0, TOP_EMPTY, 0));
        // oversized height acts as full depth
        script.push_back(height_row(9'h1FF));
        script.push_back(checked_row(OP_READ, 15, 255, 15, 0, 0, 8'hAA, 8'h55, 255, 1));
        script.push_back(checked_row(OP_WRITE, 15, 255, 15, 0, 0, 0, 0, 99, 1));
        // single layer
        script.push_back(height_row(9'd1));
        script.push_back(checked_row(OP_WRITE, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1));
        script.push_back(checked_row(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, TOP_EMPTY, 1));
        script.push_back(checked_row(OP_WRITE, 0, 1, 0, 8'h03, 8'h03, 0, 0, TOP_EMPTY, 0));
        script.push_back(height_row(9'd256));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                drain();
                write_height(script[i].height);
            end else begin
                send_access(script[i].op, script[i].x, script[i].y, script[i].z,
                            script[i].id, script[i].st, script[i].typed, script[i].want);
            end
        end

        drain();
        write_height(9'd256);
        run_phase(16, 620);
        drain();
        write_height(HEIGHT_W'($urandom_range(2, 255)));
        run_phase(86, 620);
        drain();
        write_height(9'h1FF);
        run_phase(0, 610);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_fault($sformatf("%0d results never arrived", pending_results.size()));
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/vxs_pkg.sv
rtl/vxs_ram.sv
rtl/voxel_store_with_column_top.sv
tb/sv/voxel_store_with_column_top_test.sv
